// ----- hdl/mfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Mixed fraction ALU package
// Shared types and constants for the mixed fraction arithmetic block.
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int unsigned OpW   = 64;
  localparam int unsigned ProdW = 128;
  localparam int unsigned CntMW = 6;
  localparam int unsigned CntDW = 7;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_MUL = 2'd1;
  localparam logic [1:0] MODE_DIV = 2'd2;
  localparam logic [1:0] MODE_CMP = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] left_integer;
    logic signed [31:0] left_numerator;
    logic [30:0]        left_denominator;
    logic signed [31:0] right_integer;
    logic signed [31:0] right_numerator;
    logic [30:0]        right_denominator;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] result_integer;
    logic signed [31:0] result_numerator;
    logic [30:0]        result_denominator;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               overflow;
  } item_out_t;

endpackage

// ----- hdl/mixed_fraction_alu.sv -----
// ----------------------------------------------------------------------------
// Mixed fraction ALU
// Add, multiply, divide and compare of two mixed fractions, with the sum,
// product and quotient brought to proper form and reduced by a Euclid GCD.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. The
// block then runs on its own and holds busy high until the result is out. The
// result appears on result_o, marked by done_o for exactly one cycle, and the
// receiver cannot stall it; busy is already low in the strobe cycle, so the
// next item can be taken at the edge that ends it. One item is in flight.
// The work is done by a sequencer driving a bit-serial 64 by 64 multiplier
// and a 128-bit restoring divider. Compare takes four products. Multiply
// and divide take four products, add takes five, and one proper-form
// division follows: with no remainder the result goes straight out.
// Otherwise the Euclid divisions and two reducing divisions follow. Divide
// can need about 135 Euclid divisions on its 93-bit denominators.
// Reset clears the sequencer and the units; no item is in flight after it.
// WIDTH sets the signed range that the overflow flag checks.
// ----------------------------------------------------------------------------
module mixed_fraction_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mfa_pkg::item_in_t   item_i,
  output logic                done_o,
  output mfa_pkg::item_out_t  result_o
);

  localparam int unsigned PW = mfa_pkg::ProdW;
  localparam int unsigned OW = mfa_pkg::OpW;
  localparam logic signed [PW-1:0] SMax = (PW'(1) <<< (WIDTH-1)) - PW'(1);
  localparam logic signed [PW-1:0] SMin = -SMax - PW'(1);
  localparam logic [PW-1:0]        DLim = PW'(1) << (WIDTH-1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_N1   = 4'd1;
  localparam logic [3:0] ST_N2   = 4'd2;
  localparam logic [3:0] ST_M0   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_FIX  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_GCD  = 4'd8;
  localparam logic [3:0] ST_RED1 = 4'd9;
  localparam logic [3:0] ST_RED2 = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]               state_q;
  logic                     kick_q;
  logic                     done_q;
  mfa_pkg::item_in_t        in_q;
  mfa_pkg::item_out_t       res_q;
  mfa_pkg::item_out_t       res_d;
  logic signed [OW-1:0]     n1_q;
  logic signed [OW-1:0]     n2_q;
  logic signed [PW-1:0]     num_q;
  logic signed [PW-1:0]     den_q;
  logic signed [PW-1:0]     base_q;
  logic [PW-1:0]            r_q;
  logic [PW-1:0]            ga_q;
  logic [PW-1:0]            gb_q;
  logic                     sn_q;

  logic signed [OW-1:0]     li64, ln64, ld64, ri64, rn64, rd64;
  logic [30:0]              ld_eff, rd_eff;
  logic signed [OW-1:0]     mul_a, mul_b;
  logic                     mul_start, mul_done;
  logic signed [PW-1:0]     mul_p;
  logic [PW-1:0]            div_n, div_d, div_q, div_r;
  logic                     div_start, div_done;
  logic                     in_mul_state;
  logic signed [PW-1:0]     rs;
  logic signed [PW-1:0]     diff;

  assign ld_eff = (in_q.left_denominator == '0) ? 31'd1 : in_q.left_denominator;
  assign rd_eff = (in_q.right_denominator == '0) ? 31'd1 : in_q.right_denominator;
  assign li64   = {{(OW-32){in_q.left_integer[31]}}, in_q.left_integer};
  assign ln64   = {{(OW-32){in_q.left_numerator[31]}}, in_q.left_numerator};
  assign ri64   = {{(OW-32){in_q.right_integer[31]}}, in_q.right_integer};
  assign rn64   = {{(OW-32){in_q.right_numerator[31]}}, in_q.right_numerator};
  assign ld64   = {{(OW-31){1'b0}}, ld_eff};
  assign rd64   = {{(OW-31){1'b0}}, rd_eff};

  always_comb begin
    mul_a = li64;
    mul_b = ld64;
    unique case (state_q)
      ST_N2: begin
        mul_a = ri64;
        mul_b = rd64;
      end
      ST_M0: begin
        unique case (in_q.mode)
          mfa_pkg::MODE_ADD: begin
            mul_a = ln64;
            mul_b = rd64;
          end
          mfa_pkg::MODE_MUL: begin
            mul_a = n1_q;
            mul_b = n2_q;
          end
          default: begin
            mul_a = n1_q;
            mul_b = rd64;
          end
        endcase
      end
      ST_M1: begin
        mul_a = rn64;
        mul_b = ld64;
      end
      ST_M2: begin
        if (in_q.mode == mfa_pkg::MODE_ADD || in_q.mode == mfa_pkg::MODE_MUL) begin
          mul_a = ld64;
          mul_b = rd64;
        end else begin
          mul_a = n2_q;
          mul_b = ld64;
        end
      end
      default: begin
        mul_a = li64;
        mul_b = ld64;
      end
    endcase
  end

  always_comb begin
    div_n = ga_q;
    div_d = gb_q;
    unique case (state_q)
      ST_DIV: begin
        div_n = num_q[PW-1] ? PW'(-num_q) : PW'(num_q);
        div_d = PW'(den_q);
      end
      ST_RED1: begin
        div_n = r_q;
        div_d = ga_q;
      end
      ST_RED2: begin
        div_n = PW'(den_q);
        div_d = ga_q;
      end
      default: begin
        div_n = ga_q;
        div_d = gb_q;
      end
    endcase
  end

  assign in_mul_state = (state_q == ST_N1) || (state_q == ST_N2) || (state_q == ST_M0) ||
                        (state_q == ST_M1) || (state_q == ST_M2);
  assign mul_start    = kick_q && in_mul_state;
  assign div_start    = kick_q && ((state_q == ST_DIV) || (state_q == ST_RED1) ||
                        (state_q == ST_RED2) || ((state_q == ST_GCD) && (gb_q != '0)));

  mfa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  mfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quot_o  (div_q),
    .rem_o   (div_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kick_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_N1;
            kick_q  <= 1'b1;
          end
        end
        ST_N1, ST_N2, ST_M0, ST_M1, ST_M2: begin
          if (kick_q) begin
            kick_q <= 1'b0;
          end else if (mul_done) begin
            kick_q <= 1'b1;
            unique case (state_q)
              ST_N1:   state_q <= ST_N2;
              ST_N2:   state_q <= ST_M0;
              ST_M0:   state_q <= (in_q.mode == mfa_pkg::MODE_ADD) ? ST_M1 : ST_M2;
              ST_M1:   state_q <= ST_M2;
              default: state_q <= (in_q.mode == mfa_pkg::MODE_CMP) ? ST_OUT : ST_FIX;
            endcase
          end
        end
        ST_FIX: begin
          state_q <= ST_DIV;
          kick_q  <= 1'b1;
        end
        ST_DIV: begin
          if (kick_q) begin
            kick_q <= 1'b0;
          end else if (div_done) begin
            kick_q  <= 1'b1;
            state_q <= (div_r == '0) ? ST_OUT : ST_GCD;
          end
        end
        ST_GCD: begin
          if (kick_q && gb_q == '0) begin
            state_q <= ST_RED1;
          end else if (kick_q) begin
            kick_q <= 1'b0;
          end else if (div_done) begin
            kick_q <= 1'b1;
          end
        end
        ST_RED1, ST_RED2: begin
          if (kick_q) begin
            kick_q <= 1'b0;
          end else if (div_done) begin
            kick_q  <= 1'b1;
            state_q <= (state_q == ST_RED1) ? ST_RED2 : ST_OUT;
          end
        end
        ST_OUT: begin
          kick_q  <= 1'b0;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
          kick_q  <= 1'b0;
        end
      endcase
    end
  end

  assign rs   = sn_q ? -$signed(r_q) : $signed(r_q);
  assign diff = num_q - den_q;

  always_comb begin
    res_d = '0;
    if (in_q.mode == mfa_pkg::MODE_CMP) begin
      res_d.result_denominator = 31'd1;
      res_d.is_equal           = (diff == '0);
      res_d.is_less            = diff[PW-1];
      res_d.is_greater         = !diff[PW-1] && (diff != '0);
    end else begin
      res_d.result_integer     = base_q[31:0];
      res_d.result_numerator   = rs[31:0];
      res_d.result_denominator = den_q[30:0];
      res_d.overflow           = (base_q > SMax) || (base_q < SMin) ||
                                 (rs > SMax) || (rs < SMin) || (PW'(den_q) >= DLim);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          in_q <= item_i;
        end
      end
      ST_N1: begin
        if (!kick_q && mul_done) begin
          n1_q <= mul_p[OW-1:0] + ln64;
        end
      end
      ST_N2: begin
        if (!kick_q && mul_done) begin
          n2_q <= mul_p[OW-1:0] + rn64;
        end
      end
      ST_M0: begin
        if (!kick_q && mul_done) begin
          num_q <= mul_p;
        end
      end
      ST_M1: begin
        if (!kick_q && mul_done) begin
          num_q <= num_q + mul_p;
        end
      end
      ST_M2: begin
        if (!kick_q && mul_done) begin
          den_q  <= mul_p;
          base_q <= (in_q.mode == mfa_pkg::MODE_ADD) ?
                    ({{(PW-32){in_q.left_integer[31]}}, in_q.left_integer} +
                     {{(PW-32){in_q.right_integer[31]}}, in_q.right_integer}) : '0;
        end
      end
      ST_FIX: begin
        if (den_q == '0) begin
          den_q <= PW'(1);
        end else if (den_q[PW-1]) begin
          den_q <= -den_q;
          num_q <= -num_q;
        end
      end
      ST_DIV: begin
        if (kick_q) begin
          sn_q <= num_q[PW-1];
        end else if (div_done) begin
          base_q <= sn_q ? base_q - $signed(div_q) : base_q + $signed(div_q);
          r_q    <= div_r;
          ga_q   <= div_r;
          gb_q   <= PW'(den_q);
          if (div_r == '0) begin
            den_q <= PW'(1);
          end
        end
      end
      ST_GCD: begin
        if (!kick_q && div_done) begin
          ga_q <= gb_q;
          gb_q <= div_r;
        end
      end
      ST_RED1: begin
        if (!kick_q && div_done) begin
          r_q <= div_q;
        end
      end
      ST_RED2: begin
        if (!kick_q && div_done) begin
          den_q <= $signed(div_q);
        end
      end
      ST_OUT: begin
        res_q <= res_d;
      end
      default: begin
      end
    endcase
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/mfa_mul.sv -----
// ----------------------------------------------------------------------------
// Mixed fraction ALU multiplier
// Signed 64 by 64 bit shift-add multiplier, one partial product per cycle.
// ----------------------------------------------------------------------------
module mfa_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mfa_pkg::OpW-1:0]      a_i,
  input  logic signed [mfa_pkg::OpW-1:0]      b_i,
  output logic                                done_o,
  output logic signed [mfa_pkg::ProdW-1:0]    prod_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [mfa_pkg::CntMW-1:0]     cnt_q;
  logic [mfa_pkg::ProdW-1:0]     acc_q;
  logic [mfa_pkg::ProdW-1:0]     ash_q;
  logic [mfa_pkg::OpW-1:0]       bsh_q;
  logic                          neg_q;
  logic [mfa_pkg::OpW-1:0]       amag;
  logic [mfa_pkg::OpW-1:0]       bmag;

  assign amag = a_i[mfa_pkg::OpW-1] ? -a_i : a_i;
  assign bmag = b_i[mfa_pkg::OpW-1] ? -b_i : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= {{(mfa_pkg::ProdW-mfa_pkg::OpW){1'b0}}, amag};
      bsh_q <= bmag;
      neg_q <= a_i[mfa_pkg::OpW-1] ^ b_i[mfa_pkg::OpW-1];
    end else if (busy_q) begin
      if (bsh_q[0]) begin
        acc_q <= acc_q + ash_q;
      end
      ash_q <= ash_q << 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ----- hdl/mfa_div.sv -----
// ----------------------------------------------------------------------------
// Mixed fraction ALU divider
// Unsigned 128-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mfa_pkg::ProdW-1:0]     num_i,
  input  logic [mfa_pkg::ProdW-1:0]     den_i,
  output logic                          done_o,
  output logic [mfa_pkg::ProdW-1:0]     quot_o,
  output logic [mfa_pkg::ProdW-1:0]     rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [mfa_pkg::CntDW-1:0]     cnt_q;
  logic [mfa_pkg::ProdW:0]       rem_q;
  logic [mfa_pkg::ProdW-1:0]     nsh_q;
  logic [mfa_pkg::ProdW-1:0]     quo_q;
  logic [mfa_pkg::ProdW-1:0]     den_q;
  logic [mfa_pkg::ProdW:0]       trial;
  logic                          fits;

  assign trial = {rem_q[mfa_pkg::ProdW-1:0], nsh_q[mfa_pkg::ProdW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nsh_q <= num_i;
      quo_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, den_q} : trial;
      nsh_q <= nsh_q << 1;
      quo_q <= {quo_q[mfa_pkg::ProdW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[mfa_pkg::ProdW-1:0];

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Mixed fraction ALU testbench
// Sends add, multiply, divide and compare items to the block, predicts each
// result with an exact wide-integer model and checks every field of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  mfa_pkg::item_in_t  item_i;
  logic               done_o;
  mfa_pkg::item_out_t result_o;

  mfa_pkg::item_out_t expected_q[$];
  int                 error_count;
  int                 item_count;
  int                 result_count;
  int                 mode_count[4];
  bit                 allow_gaps;

  mixed_fraction_alu #(
    .WIDTH(32)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [127:0] den_of(logic [30:0] d);
    return (d == 0) ? 128'sd1 : $signed({97'd0, d});
  endfunction

  function automatic logic signed [127:0] gcd_of(logic signed [127:0] a,
                                                  logic signed [127:0] b);
    logic signed [127:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic mfa_pkg::item_out_t proper_form(logic signed [127:0] base,
                                                     logic signed [127:0] num,
                                                     logic signed [127:0] den);
    mfa_pkg::item_out_t r;
    logic signed [127:0] q;
    logic signed [127:0] rem;
    logic signed [127:0] g;
    logic signed [127:0] lim;
    r = '0;
    if (den == 0) den = 1;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    q = num / den;
    rem = num % den;
    base = base + q;
    if (rem == 0) begin
      den = 1;
    end else begin
      g = gcd_of((rem < 0) ? -rem : rem, den);
      rem = rem / g;
      den = den / g;
    end
    lim = 128'sd1 <<< 31;
    r.result_integer = base[31:0];
    r.result_numerator = rem[31:0];
    r.result_denominator = den[30:0];
    r.overflow = (base < -lim) || (base >= lim) || (rem < -lim) || (rem >= lim)
                 || (den >= lim);
    return r;
  endfunction

  function automatic mfa_pkg::item_out_t fraction_result(mfa_pkg::item_in_t it);
    mfa_pkg::item_out_t r;
    logic signed [127:0] li, ln, ld, ri, rn, rd, n1, n2, d;
    li = it.left_integer;
    ln = it.left_numerator;
    ld = den_of(it.left_denominator);
    ri = it.right_integer;
    rn = it.right_numerator;
    rd = den_of(it.right_denominator);
    n1 = li * ld + ln;
    n2 = ri * rd + rn;
    r = '0;
    case (it.mode)
      mfa_pkg::MODE_ADD: r = proper_form(li + ri, ln * rd + rn * ld, ld * rd);
      mfa_pkg::MODE_MUL: r = proper_form(0, n1 * n2, ld * rd);
      mfa_pkg::MODE_DIV: r = proper_form(0, n1 * rd, ld * n2);
      default: begin
        d = n1 * rd - n2 * ld;
        r.result_denominator = 31'd1;
        r.is_equal = (d == 0);
        r.is_less = (d < 0);
        r.is_greater = (d > 0);
      end
    endcase
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_item(mfa_pkg::item_in_t it);
    if (allow_gaps && ($urandom_range(0, 3) == 0)) begin
      start <= 1'b0;
      idle_cycles($urandom_range(1, 13));
    end
    item_i <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(fraction_result(it));
    item_count++;
    mode_count[it.mode]++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(0, 20);
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(0, 12));
      1: return 31'($urandom_range(0, 5000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic mfa_pkg::item_in_t rand_item(logic [1:0] m);
    mfa_pkg::item_in_t it;
    it.mode = m;
    it.left_integer = rand_word();
    it.left_numerator = rand_word();
    it.left_denominator = rand_den();
    it.right_integer = rand_word();
    it.right_numerator = rand_word();
    it.right_denominator = rand_den();
    return it;
  endfunction

  task automatic test_directed();
    mfa_pkg::item_in_t it;
    logic [1:0] m;
    for (int k = 0; k < 4; k++) begin
      m = k[1:0];
      it = '{m, 32'sd3, 32'sd1, 31'd2, 32'sd1, 32'sd1, 31'd3};
      send_item(it);
      it = '{m, 32'sd3, -32'sd1, 31'd2, -32'sd2, 32'sd0, 31'd0};
      send_item(it);
      it = '{m, 32'sh80000000, 32'sh80000000, 31'd1, 32'sh80000000,
             32'sh80000000, 31'h7fffffff};
      send_item(it);
      it = '{m, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff,
             32'sh7fffffff, 31'h7fffffff};
      send_item(it);
      it = '{m, 32'sd1, 32'sd1, 31'd2, 32'sd0, 32'sd0, 31'd5};
      send_item(it);
      it = '{m, 32'sd2, 32'sd4, 31'd8, 32'sd2, 32'sd1, 31'd2};
      send_item(it);
    end
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_item(rand_item(2'($urandom_range(0, 3))));
  endtask

  always @(posedge clk_i) begin
    mfa_pkg::item_out_t exp_r;
    if (rst_ni && done_o) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", result_o);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result_o.result_integer !== exp_r.result_integer) begin
          $error("result_integer: expected %0d, actual %0d",
                 exp_r.result_integer, result_o.result_integer);
          error_count++;
        end
        if (result_o.result_numerator !== exp_r.result_numerator) begin
          $error("result_numerator: expected %0d, actual %0d",
                 exp_r.result_numerator, result_o.result_numerator);
          error_count++;
        end
        if (result_o.result_denominator !== exp_r.result_denominator) begin
          $error("result_denominator: expected %0d, actual %0d",
                 exp_r.result_denominator, result_o.result_denominator);
          error_count++;
        end
        if (result_o.is_less !== exp_r.is_less) begin
          $error("is_less: expected %0b, actual %0b", exp_r.is_less, result_o.is_less);
          error_count++;
        end
        if (result_o.is_equal !== exp_r.is_equal) begin
          $error("is_equal: expected %0b, actual %0b", exp_r.is_equal, result_o.is_equal);
          error_count++;
        end
        if (result_o.is_greater !== exp_r.is_greater) begin
          $error("is_greater: expected %0b, actual %0b",
                 exp_r.is_greater, result_o.is_greater);
          error_count++;
        end
        if (result_o.overflow !== exp_r.overflow) begin
          $error("overflow: expected %0b, actual %0b", exp_r.overflow, result_o.overflow);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(500 * 20000 * 10 * 6);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    error_count = 0;
    item_count = 0;
    result_count = 0;
    allow_gaps = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    allow_gaps = 1'b1;
    test_random(380);
    allow_gaps = 1'b0;
    test_random(50);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    idle_cycles(50);
    $display("Ran %0d items (add %0d, mul %0d, div %0d, cmp %0d), %0d results checked.",
             item_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             result_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mfa_pkg.sv
hdl/mfa_mul.sv
hdl/mfa_div.sv
hdl/mixed_fraction_alu.sv
sim/testbench.sv
